### sv/lpc_pkg.sv
// Shared constants and codes for the lagged Pearson correlation block.
package lpc_pkg;

  // Defaults for the top-level parameters
  localparam int MAX_SAMPLES_DEF = 1024;
  localparam int SAMPLE_BITS_DEF = 16;

  // Fixed port widths
  localparam int IN_SAMPLE_BITS = 16;
  localparam int LAG_BITS       = 11;
  localparam int COUNT_BITS     = 11;
  localparam int COEF_BITS      = 16;

  // Q2.14 result: quotient of 2^30*num^2/(vx*vy) is at most 2^30
  localparam int FRAC_BITS = 14;
  localparam int QUOT_BITS = 2 * (FRAC_BITS + 1) + 1;
  localparam int ROOT_BITS = FRAC_BITS + 2;
  localparam logic [COEF_BITS-1:0] ONE_Q = COEF_BITS'(1 << FRAC_BITS);

  // Default operand width of the serial multiplier and remainder width of the divider
  localparam int VAL_BITS_DEF = 2 * SAMPLE_BITS_DEF + 2 * $clog2(MAX_SAMPLES_DEF + 1);
  localparam int REM_BITS_DEF = 2 * VAL_BITS_DEF + 1;

  // Action codes
  localparam logic [1:0] ACT_LOAD    = 2'd0;
  localparam logic [1:0] ACT_COMPUTE = 2'd1;
  localparam logic [1:0] ACT_CLEAR   = 2'd2;

  // Status codes
  localparam logic [1:0] ST_OK         = 2'd0;
  localparam logic [1:0] ST_NO_OVERLAP = 2'd1;
  localparam logic [1:0] ST_ZERO_VAR   = 2'd2;

endpackage

### sv/lpc_ram.sv
// Simple dual-port RAM with registered read data.
module lpc_ram
  import lpc_pkg::*;
#(
  parameter int WIDTH = SAMPLE_BITS_DEF,
  parameter int DEPTH = MAX_SAMPLES_DEF
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

### sv/lpc_mul.sv
// Shift-and-add serial multiplier, one multiplier bit per cycle.
module lpc_mul
  import lpc_pkg::*;
#(
  parameter int W = VAL_BITS_DEF
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  logic [W-1:0]     a,
  input  logic [W-1:0]     b,
  output logic [2*W-1:0]   prod,
  output logic             done
);

  localparam int CNTW = $clog2(W + 1);

  logic [2*W-1:0] acc;
  logic [2*W-1:0] mcand;
  logic [W-1:0]   mplier;
  logic [CNTW-1:0] cnt;
  logic           busy;

  // Control
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= CNTW'(W);
      end else if (busy) begin
        cnt <= cnt - 1'b1;
        if (cnt == CNTW'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // Datapath: add shifted multiplicand where the multiplier bit is set
  always_ff @(posedge clk) begin
    if (start) begin
      acc    <= '0;
      mcand  <= (2*W)'(a);
      mplier <= b;
    end else if (busy) begin
      if (mplier[0]) begin
        acc <= acc + mcand;
      end
      mcand  <= {mcand[2*W-2:0], 1'b0};
      mplier <= {1'b0, mplier[W-1:1]};
    end
  end

  assign prod = acc;

endmodule

### sv/lpc_div_cell.sv
// One restoring-division cell: produces one quotient bit and passes the remainder on.
module lpc_div_cell
  import lpc_pkg::*;
#(
  parameter int RW = REM_BITS_DEF
) (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 vld_in,
  input  logic [RW-1:0]        rem_in,
  input  logic [QUOT_BITS-1:0] quot_in,
  input  logic [RW-2:0]        divisor,
  output logic                 vld_out,
  output logic [RW-1:0]        rem_out,
  output logic [QUOT_BITS-1:0] quot_out
);

  logic          ge;
  logic [RW-1:0] diff;
  logic [RW-1:0] kept;

  // Trial subtract
  assign diff = rem_in - {1'b0, divisor};
  assign ge   = (rem_in >= {1'b0, divisor});
  assign kept = ge ? diff : rem_in;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld_out <= 1'b0;
    end else begin
      vld_out <= vld_in;
    end
  end

  // Remainder doubles for the next bit
  always_ff @(posedge clk) begin
    rem_out  <= {kept[RW-2:0], 1'b0};
    quot_out <= {quot_in[QUOT_BITS-2:0], ge};
  end

endmodule

### sv/lagged_pearson_correlation.sv
// Lagged Pearson correlation: load, clear and compute with a Q2.14 result.
// A load or clear can be accepted every cycle while no compute is in progress.
// Compute walks the overlap, then runs eight serial multiplications (operand width VW =
// 2*SAMPLE_BITS + 2*clog2(MAX_SAMPLES+1), 54 by default), the division cells and the root;
// zero variance stops after the fourth; no overlap goes straight to output. No item meanwhile.
// Reset empties the buffers (fill count zero) and clears out_valid; no clearing pass.
module lagged_pearson_correlation
  import lpc_pkg::*;
#(
  parameter int MAX_SAMPLES = MAX_SAMPLES_DEF,
  parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             in_valid,
  output logic                             in_stall,
  input  logic [1:0]                       action,
  input  logic signed [IN_SAMPLE_BITS-1:0] x_sample,
  input  logic signed [IN_SAMPLE_BITS-1:0] y_sample,
  input  logic signed [LAG_BITS-1:0]       lag,
  output logic                             out_valid,
  input  logic                             out_stall,
  output logic signed [COEF_BITS-1:0]      coefficient,
  output logic [1:0]                       status,
  output logic [COUNT_BITS-1:0]            overlap_count
);

  localparam int AW    = $clog2(MAX_SAMPLES);
  localparam int CW    = $clog2(MAX_SAMPLES + 1);
  localparam int KW    = (CW > LAG_BITS) ? CW : LAG_BITS;
  localparam int SXW   = SAMPLE_BITS + CW;
  localparam int SUMW  = 2 * SAMPLE_BITS + CW;
  localparam int VW    = 2 * SAMPLE_BITS + 2 * CW;
  localparam int PW    = 2 * VW;
  localparam int RW    = PW + 1;
  localparam int SRCW  = 2 * ROOT_BITS;
  localparam int REM_W = ROOT_BITS + 4;
  localparam int SCW   = $clog2(ROOT_BITS + 1);

  // States
  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_WALK   = 3'd1;
  localparam logic [2:0] S_MSTART = 3'd2;
  localparam logic [2:0] S_MWAIT  = 3'd3;
  localparam logic [2:0] S_DIV    = 3'd4;
  localparam logic [2:0] S_SQRT   = 3'd5;
  localparam logic [2:0] S_OUT    = 3'd6;

  // Multiply steps
  localparam logic [2:0] M_NXX = 3'd0;
  localparam logic [2:0] M_XX  = 3'd1;
  localparam logic [2:0] M_NYY = 3'd2;
  localparam logic [2:0] M_YY  = 3'd3;
  localparam logic [2:0] M_NXY = 3'd4;
  localparam logic [2:0] M_XY  = 3'd5;
  localparam logic [2:0] M_NUM = 3'd6;
  localparam logic [2:0] M_VAR = 3'd7;

  logic [2:0]    state;
  logic [CW-1:0] fill;
  logic [CW-1:0] ov;
  logic [CW-1:0] idx;
  logic [KW-1:0] xoff;
  logic [KW-1:0] yoff;
  logic          v1;
  logic          v2;
  logic [2:0]    mstep;
  logic [SCW-1:0] scnt;
  logic          div_start;

  logic accept;
  logic out_load;
  logic full;
  logic wr_en;
  logic issue;

  // Lag decode
  logic [LAG_BITS-1:0] alag;
  logic                lag_pos;
  logic                lag_neg;
  logic                no_overlap;

  // Buffers
  logic [SAMPLE_BITS-1:0] wx;
  logic [SAMPLE_BITS-1:0] wy;
  logic [AW-1:0]          rd_x;
  logic [AW-1:0]          rd_y;
  logic [SAMPLE_BITS-1:0] xq_raw;
  logic [SAMPLE_BITS-1:0] yq_raw;
  logic signed [SAMPLE_BITS-1:0] xq;
  logic signed [SAMPLE_BITS-1:0] yq;

  // Accumulation pipeline
  logic signed [SAMPLE_BITS-1:0]   x2;
  logic signed [SAMPLE_BITS-1:0]   y2;
  logic signed [2*SAMPLE_BITS-1:0] pxx;
  logic signed [2*SAMPLE_BITS-1:0] pyy;
  logic signed [2*SAMPLE_BITS-1:0] pxy;
  logic signed [SXW-1:0]  sx;
  logic signed [SXW-1:0]  sy;
  logic signed [SUMW-1:0] sxx;
  logic signed [SUMW-1:0] syy;
  logic signed [SUMW-1:0] sxy;

  // Multiply sequence
  logic [SXW-1:0]  sx_mag;
  logic [SXW-1:0]  sy_mag;
  logic [SUMW-1:0] sxy_mag;
  logic            mul_start;
  logic            mul_done;
  logic [VW-1:0]   mul_a;
  logic [VW-1:0]   mul_b;
  logic [PW-1:0]   prod;
  logic signed [VW:0] p_ext;
  logic signed [VW:0] t1;
  logic signed [VW:0] num_c;
  logic [VW-1:0]   diff_c;
  logic [VW-1:0]   vx;
  logic [VW-1:0]   vy;
  logic [VW-1:0]   nmag;
  logic            neg;
  logic [PW-1:0]   sq;
  logic [PW-1:0]   pp;

  // Division chain
  logic [QUOT_BITS:0]   cv;
  logic [RW-1:0]        cr [QUOT_BITS+1];
  logic [QUOT_BITS-1:0] cq [QUOT_BITS+1];

  // Root
  logic [SRCW-1:0]      src;
  logic [REM_W-1:0]     srem;
  logic [ROOT_BITS-1:0] root;
  logic [REM_W-1:0]     rem2;
  logic [REM_W-1:0]     trial;
  logic [ROOT_BITS:0]   rnd;
  logic [COEF_BITS-1:0] mag;

  // Pending result
  logic signed [COEF_BITS-1:0] res_coef;
  logic [1:0]                  res_status;
  logic [CW-1:0]               res_cnt;

  assign in_stall = (state != S_IDLE);
  assign accept   = in_valid && !in_stall;
  assign out_load = (state == S_OUT) && (!out_valid || !out_stall);
  assign full     = (fill == CW'(MAX_SAMPLES));
  assign wr_en    = accept && (action == ACT_LOAD) && !full;
  assign issue    = (idx != ov);

  assign alag       = lag[LAG_BITS-1] ? LAG_BITS'(-lag) : lag;
  assign lag_neg    = lag[LAG_BITS-1];
  assign lag_pos    = !lag[LAG_BITS-1] && (lag != '0);
  assign no_overlap = (KW'(alag) >= KW'(fill));

  // Sample buffers
  assign wx   = SAMPLE_BITS'(x_sample);
  assign wy   = SAMPLE_BITS'(y_sample);
  assign rd_x = AW'(KW'(idx) + xoff);
  assign rd_y = AW'(KW'(idx) + yoff);
  assign xq   = signed'(xq_raw);
  assign yq   = signed'(yq_raw);

  lpc_ram #(.WIDTH(SAMPLE_BITS), .DEPTH(MAX_SAMPLES)) u_xram (
    .clk   (clk),
    .we    (wr_en),
    .waddr (AW'(fill)),
    .wdata (wx),
    .raddr (rd_x),
    .rdata (xq_raw)
  );

  lpc_ram #(.WIDTH(SAMPLE_BITS), .DEPTH(MAX_SAMPLES)) u_yram (
    .clk   (clk),
    .we    (wr_en),
    .waddr (AW'(fill)),
    .wdata (wy),
    .raddr (rd_y),
    .rdata (yq_raw)
  );

  // Magnitudes of the sums
  assign sx_mag  = sx[SXW-1] ? SXW'(-sx) : SXW'(sx);
  assign sy_mag  = sy[SXW-1] ? SXW'(-sy) : SXW'(sy);
  assign sxy_mag = sxy[SUMW-1] ? SUMW'(-sxy) : SUMW'(sxy);

  // Multiplier operand select
  always_comb begin
    unique case (mstep)
      M_NXX: begin mul_a = VW'(ov);     mul_b = VW'(sxx[SUMW-2:0]); end
      M_XX:  begin mul_a = VW'(sx_mag); mul_b = VW'(sx_mag);        end
      M_NYY: begin mul_a = VW'(ov);     mul_b = VW'(syy[SUMW-2:0]); end
      M_YY:  begin mul_a = VW'(sy_mag); mul_b = VW'(sy_mag);        end
      M_NXY: begin mul_a = VW'(ov);     mul_b = VW'(sxy_mag);       end
      M_XY:  begin mul_a = VW'(sx_mag); mul_b = VW'(sy_mag);        end
      M_NUM: begin mul_a = nmag;        mul_b = nmag;               end
      M_VAR: begin mul_a = vx;          mul_b = vy;                 end
      default: begin mul_a = '0;        mul_b = '0;                 end
    endcase
  end

  assign mul_start = (state == S_MSTART);

  lpc_mul #(.W(VW)) u_mul (
    .clk   (clk),
    .rst   (rst),
    .start (mul_start),
    .a     (mul_a),
    .b     (mul_b),
    .prod  (prod),
    .done  (mul_done)
  );

  assign p_ext  = signed'({1'b0, prod[VW-1:0]});
  assign diff_c = VW'(t1[VW-1:0] - prod[VW-1:0]);
  assign num_c  = t1 - ((sx[SXW-1] ^ sy[SXW-1]) ? -p_ext : p_ext);

  // Division chain: floor(num^2 * 2^30 / (vx*vy)), one bit per cell
  assign cv[0] = div_start;
  assign cr[0] = {1'b0, sq};
  assign cq[0] = '0;

  for (genvar g = 0; g < QUOT_BITS; g++) begin : g_div
    lpc_div_cell #(.RW(RW)) u_cell (
      .clk      (clk),
      .rst      (rst),
      .vld_in   (cv[g]),
      .rem_in   (cr[g]),
      .quot_in  (cq[g]),
      .divisor  (pp),
      .vld_out  (cv[g+1]),
      .rem_out  (cr[g+1]),
      .quot_out (cq[g+1])
    );
  end

  // Root step and final rounding
  assign rem2  = {srem[REM_W-3:0], src[SRCW-1:SRCW-2]};
  assign trial = REM_W'({root, 2'b01});
  assign rnd   = ({1'b0, root} + 1'b1) >> 1;
  assign mag   = (COEF_BITS'(rnd) > ONE_Q) ? ONE_Q : COEF_BITS'(rnd);

  // Control
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      fill      <= '0;
      idx       <= '0;
      v1        <= 1'b0;
      v2        <= 1'b0;
      mstep     <= M_NXX;
      scnt      <= '0;
      div_start <= 1'b0;
    end else begin
      div_start <= 1'b0;
      unique case (state)
        S_IDLE: begin
          if (accept) begin
            case (action)
              ACT_LOAD: begin
                if (!full) begin
                  fill <= fill + 1'b1;
                end
              end
              ACT_CLEAR: fill <= '0;
              ACT_COMPUTE: begin
                idx   <= '0;
                state <= no_overlap ? S_OUT : S_WALK;
              end
              default: ;
            endcase
          end
        end
        S_WALK: begin
          if (issue) begin
            idx <= idx + 1'b1;
          end
          v1 <= issue;
          v2 <= v1;
          if (!issue && !v1 && !v2) begin
            mstep <= M_NXX;
            state <= S_MSTART;
          end
        end
        S_MSTART: state <= S_MWAIT;
        S_MWAIT: begin
          if (mul_done) begin
            if (mstep == M_VAR) begin
              div_start <= 1'b1;
              state     <= S_DIV;
            end else if (mstep == M_YY && (vx == '0 || diff_c == '0)) begin
              state <= S_OUT;
            end else begin
              mstep <= mstep + 1'b1;
              state <= S_MSTART;
            end
          end
        end
        S_DIV: begin
          if (cv[QUOT_BITS]) begin
            scnt  <= SCW'(ROOT_BITS);
            state <= S_SQRT;
          end
        end
        S_SQRT: begin
          if (scnt == '0) begin
            state <= S_OUT;
          end else begin
            scnt <= scnt - 1'b1;
          end
        end
        S_OUT: begin
          if (out_load) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // Datapath
  always_ff @(posedge clk) begin
    // Compute request: latch offsets and the empty-overlap result
    if (state == S_IDLE && accept && action == ACT_COMPUTE) begin
      ov         <= CW'(KW'(fill) - KW'(alag));
      xoff       <= lag_pos ? KW'(alag) : '0;
      yoff       <= lag_neg ? KW'(alag) : '0;
      sx         <= '0;
      sy         <= '0;
      sxx        <= '0;
      syy        <= '0;
      sxy        <= '0;
      res_coef   <= '0;
      res_status <= ST_NO_OVERLAP;
      res_cnt    <= '0;
    end

    // Products, then sums
    if (v1) begin
      x2  <= xq;
      y2  <= yq;
      pxx <= xq * xq;
      pyy <= yq * yq;
      pxy <= xq * yq;
    end
    if (state == S_WALK && v2) begin
      sx  <= sx + SXW'(x2);
      sy  <= sy + SXW'(y2);
      sxx <= sxx + SUMW'(pxx);
      syy <= syy + SUMW'(pyy);
      sxy <= sxy + SUMW'(pxy);
    end

    // Multiply results
    if (state == S_MWAIT && mul_done) begin
      case (mstep)
        M_NXX, M_NYY: t1 <= p_ext;
        M_XX:  vx <= diff_c;
        M_YY: begin
          vy         <= diff_c;
          res_coef   <= '0;
          res_status <= ST_ZERO_VAR;
          res_cnt    <= ov;
        end
        M_NXY: t1 <= sxy[SUMW-1] ? -p_ext : p_ext;
        M_XY: begin
          neg  <= num_c[VW];
          nmag <= num_c[VW] ? VW'(-num_c) : VW'(num_c);
        end
        M_NUM: sq <= prod;
        M_VAR: pp <= prod;
        default: ;
      endcase
    end

    // Root: start from the quotient, then one result bit per cycle
    if (state == S_DIV && cv[QUOT_BITS]) begin
      src  <= SRCW'(cq[QUOT_BITS]);
      srem <= '0;
      root <= '0;
    end
    if (state == S_SQRT) begin
      if (scnt != '0) begin
        src <= {src[SRCW-3:0], 2'b00};
        if (rem2 >= trial) begin
          srem <= rem2 - trial;
          root <= {root[ROOT_BITS-2:0], 1'b1};
        end else begin
          srem <= rem2;
          root <= {root[ROOT_BITS-2:0], 1'b0};
        end
      end else begin
        res_coef   <= neg ? -signed'(mag) : signed'(mag);
        res_status <= ST_OK;
        res_cnt    <= ov;
      end
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      coefficient   <= res_coef;
      status        <= res_status;
      overlap_count <= COUNT_BITS'(res_cnt);
    end
  end

endmodule

### sim/lagged_pearson_correlation_test.sv
// Self-checking testbench for the lagged Pearson correlation block.
`timescale 1ns / 100ps

module lagged_pearson_correlation_test;
  import lpc_pkg::*;

  localparam int DEPTH = MAX_SAMPLES_DEF;
  localparam int CYCLE_LIMIT = 3000000;
  localparam logic [1:0] ACT_UNUSED = 2'd3;

  typedef logic signed [255:0] wide_t;

  typedef struct {
    logic [1:0]         act;
    logic signed [15:0] xs;
    logic signed [15:0] ys;
    logic signed [10:0] lg;
    bit                 drain;  // hold until all results are back
  } item_t;

  typedef struct {
    logic signed [15:0] coef;
    logic [1:0]         st;
    logic [10:0]        cnt;
  } corr_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [1:0] action = ACT_LOAD;
  logic signed [15:0] x_sample = '0;
  logic signed [15:0] y_sample = '0;
  logic signed [10:0] lag = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic signed [15:0] coefficient;
  logic [1:0] status;
  logic [10:0] overlap_count;

  lagged_pearson_correlation dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall),
    .action(action), .x_sample(x_sample), .y_sample(y_sample), .lag(lag),
    .out_valid(out_valid), .out_stall(out_stall),
    .coefficient(coefficient), .status(status), .overlap_count(overlap_count)
  );

  always #5 clk = ~clk;

  item_t pending[$];
  corr_t corr_expected[$];
  logic signed [15:0] x_buf[DEPTH];
  logic signed [15:0] y_buf[DEPTH];
  int fill = 0;
  int errors = 0;
  int tx_wait = 0;
  int rx_wait = 0;
  int sent = 0;
  bit calm = 0;
  longint cycles = 0;

  // Exact coefficient at a lag over the current buffer contents
  function automatic corr_t correlate(logic signed [10:0] lg);
    corr_t r;
    int alag, xo, yo, ov;
    longint sx, sy, sxx, syy, sxy, xv, yv;
    wide_t vx, vy, num, a, p, b;
    bit neg;
    int lo, hi, mid;
    longint t;
    alag = (lg < 0) ? -int'(lg) : int'(lg);
    r = '{coef: '0, st: ST_NO_OVERLAP, cnt: '0};
    if (alag >= fill) return r;
    ov = fill - alag;
    xo = (lg > 0) ? alag : 0;
    yo = (lg < 0) ? alag : 0;
    sx = 0; sy = 0; sxx = 0; syy = 0; sxy = 0;
    for (int i = 0; i < ov; i++) begin
      xv = x_buf[i + xo];
      yv = y_buf[i + yo];
      sx += xv; sy += yv;
      sxx += xv * xv; syy += yv * yv; sxy += xv * yv;
    end
    r.cnt = 11'(ov);
    vx = wide_t'(ov) * wide_t'(sxx) - wide_t'(sx) * wide_t'(sx);
    vy = wide_t'(ov) * wide_t'(syy) - wide_t'(sy) * wide_t'(sy);
    if (vx == 0 || vy == 0) begin
      r.st = ST_ZERO_VAR;
      return r;
    end
    num = wide_t'(ov) * wide_t'(sxy) - wide_t'(sx) * wide_t'(sy);
    neg = num < 0;
    if (neg) num = -num;
    // largest q with (2q-1)^2 * vx*vy <= 2^30 * num^2
    a = num * num * (wide_t'(1) <<< 30);
    p = vx * vy;
    lo = 0;
    hi = 16384;
    while (lo < hi) begin
      mid = (lo + hi + 1) / 2;
      t = 2 * longint'(mid) - 1;
      b = wide_t'(t * t) * p;
      if (b <= a) lo = mid;
      else hi = mid - 1;
    end
    r.coef = neg ? -16'(lo) : 16'(lo);
    r.st = ST_OK;
    return r;
  endfunction

  // Update the buffer copy for one accepted transfer
  task automatic apply_item(item_t it);
    case (it.act)
      ACT_LOAD: begin
        if (fill < DEPTH) begin
          x_buf[fill] = it.xs;
          y_buf[fill] = it.ys;
          fill++;
        end
      end
      ACT_CLEAR: fill = 0;
      ACT_COMPUTE: corr_expected = {corr_expected, correlate(it.lg)};
      default: ;
    endcase
  endtask

  function automatic int draw_wait();
    return calm ? 0 : $urandom_range(0, 3);
  endfunction

  // Driver: one item from the queue, held while stalled
  item_t cur;
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) begin
        apply_item(cur);
        sent++;
        if (sent % 60 == 0) calm = ($urandom_range(0, 2) == 0);
      end
      if (!in_valid || !in_stall) begin
        if (tx_wait != 0) begin
          tx_wait--;
          in_valid <= 1'b0;
        end else if (pending.size() != 0 &&
                     (!pending[0].drain || corr_expected.size() == 0)) begin
          cur = pending.pop_front();
          action <= cur.act;
          x_sample <= cur.xs;
          y_sample <= cur.ys;
          lag <= cur.lg;
          in_valid <= 1'b1;
          tx_wait = draw_wait();
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Monitor: random stall, compare each result transfer
  always @(posedge clk) begin
    corr_t e;
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end else if (!rst) begin
      if (out_valid && !out_stall) begin
        if (corr_expected.size() == 0) begin
          errors++;
          if (errors <= 10)
            $display("unexpected result coef=%0d status=%0d count=%0d",
                     coefficient, status, overlap_count);
        end else begin
          e = corr_expected.pop_front();
          if (coefficient !== e.coef || status !== e.st || overlap_count !== e.cnt) begin
            errors++;
            if (errors <= 10)
              $display("mismatch: exp coef=%0d status=%0d count=%0d, got %0d %0d %0d",
                       e.coef, e.st, e.cnt, coefficient, status, overlap_count);
          end
        end
        rx_wait = draw_wait();
      end
      out_stall <= (rx_wait != 0);
      if (rx_wait != 0) rx_wait--;
    end
  end

  task automatic add(logic [1:0] act, logic signed [15:0] xs, logic signed [15:0] ys,
                     logic signed [10:0] lg, bit drain = 0);
    pending = {pending, item_t'{act: act, xs: xs, ys: ys, lg: lg, drain: drain}};
  endtask

  function automatic logic signed [15:0] any_sample();
    case ($urandom_range(0, 7))
      0: return 16'sh7fff;
      1: return 16'sh8000;
      2: return 16'(int'($urandom_range(0, 15)) - 8);
      default: return 16'($urandom_range(0, 65535));
    endcase
  endfunction

  // Stimulus
  initial begin
    int n, depth, style;
    logic signed [15:0] xs, ys;
    // directed: empty, single pair, extremes, unused code, clear
    add(ACT_COMPUTE, 0, 0, 0);
    add(ACT_LOAD, 16'sh7fff, 16'sh8000, 0);
    add(ACT_COMPUTE, 0, 0, 0);
    add(ACT_LOAD, 16'sh8000, 16'sh7fff, 0);
    add(ACT_LOAD, 0, 0, 0);
    add(ACT_LOAD, -1, 1, 0);
    add(ACT_COMPUTE, 0, 0, 0);
    add(ACT_COMPUTE, 0, 0, 1);
    add(ACT_COMPUTE, 0, 0, -1);
    add(ACT_COMPUTE, 0, 0, 3);
    add(ACT_COMPUTE, 0, 0, 4);
    add(ACT_COMPUTE, 0, 0, 11'sd1023);
    add(ACT_COMPUTE, 0, 0, -11'sd1023);
    add(ACT_UNUSED, 16'shffff, 16'shffff, -1);
    add(ACT_CLEAR, 0, 0, 0);
    add(ACT_COMPUTE, 0, 0, 0);
    // constant x gives zero variance; y = x gives exactly one
    for (int i = 0; i < 4; i++) add(ACT_LOAD, 5, 16'(i * 3), 0);
    add(ACT_COMPUTE, 0, 0, 0);
    add(ACT_CLEAR, 0, 0, 0);
    for (int i = 0; i < 4; i++) add(ACT_LOAD, 16'(i), 16'(i), 0);
    add(ACT_COMPUTE, 0, 0, 0, 1);
    add(ACT_CLEAR, 0, 0, 0);

    // random phases: clear, fill, several computes
    while (pending.size() < 430) begin
      add(ACT_CLEAR, 0, 0, 0);
      depth = ($urandom_range(0, 9) == 0) ? $urandom_range(41, 200) : $urandom_range(1, 40);
      style = $urandom_range(0, 3);
      for (int i = 0; i < depth; i++) begin
        xs = any_sample();
        case (style)
          0: ys = xs;
          1: ys = -xs;
          2: ys = xs + 16'(int'($urandom_range(0, 200)) - 100);
          default: ys = any_sample();
        endcase
        add(ACT_LOAD, xs, ys, 11'($urandom));
        if ($urandom_range(0, 30) == 0) add(ACT_UNUSED, any_sample(), any_sample(), 11'($urandom));
      end
      n = $urandom_range(1, 4);
      for (int i = 0; i < n; i++) begin
        if ($urandom_range(0, 4) == 0) add(ACT_COMPUTE, any_sample(), any_sample(), 11'($urandom));
        else add(ACT_COMPUTE, any_sample(), any_sample(),
                 11'(int'($urandom_range(0, 2 * depth)) - depth), $urandom_range(0, 9) == 0);
      end
    end

    repeat (2) @(posedge clk);
    rst <= 1'b0;
    while (pending.size() != 0 || in_valid || corr_expected.size() != 0) @(posedge clk);
    repeat (100) @(posedge clk);
    if (errors == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

### files.f
sv/lpc_pkg.sv
sv/lpc_ram.sv
sv/lpc_mul.sv
sv/lpc_div_cell.sv
sv/lagged_pearson_correlation.sv
sim/lagged_pearson_correlation_test.sv
